// ===== rtl/chunked_transfer_decoder_assert.svh =====
// assertion macros used by the checker file
`ifndef CHUNKED_TRANSFER_DECODER_ASSERT_SVH
`define CHUNKED_TRANSFER_DECODER_ASSERT_SVH

// property checked at every clock edge outside reset
`define CTD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ctd check failed");

// property checked at every clock edge, reset included
`define CTD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ctd check failed");

`endif

// ===== rtl/ctd_pkg.sv =====
package ctd_pkg;

  // width of the hex chunk size register
  localparam int SIZE_BITS = 32;
  // width of the decoded length counter
  localparam int LENGTH_BITS = 24;

  // framing characters
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;

  // status codes carried on the result channel
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // framing phase
  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_SIZE_LF = 4'd1,
    PH_EXT     = 4'd2,
    PH_EXT_CR  = 4'd3,
    PH_DATA    = 4'd4,
    PH_DATA_CR = 4'd5,
    PH_DATA_LF = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  // one decoded result beat
  typedef struct packed {
    logic [7:0]             data_byte;
    logic                   data_valid;
    logic [1:0]             status;
    logic [LENGTH_BITS-1:0] decoded_length;
  } ctd_result_t;

endpackage

// ===== rtl/ctd_in_if.sv =====
interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

// ===== rtl/ctd_out_if.sv =====
interface ctd_out_if import ctd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   data_valid;
  logic [1:0]             status;
  logic [LENGTH_BITS-1:0] decoded_length;

  modport source (output valid, data_byte, data_valid, status, decoded_length, input ready);
  modport sink (input valid, data_byte, data_valid, status, decoded_length, output ready);
endinterface

// ===== rtl/ctd_core.sv =====
module ctd_core import ctd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output ctd_result_t res
);

  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   size_acc, size_acc_next;
  logic [SIZE_BITS-1:0]   remaining, remaining_next;
  logic                   digit_seen, digit_seen_next;
  logic [LENGTH_BITS-1:0] emitted, emitted_next;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       size_line_done;

  // hex digit decode, either case
  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h57);
    end
  end

  // next phase and datapath
  always_comb begin
    phase_next      = phase;
    size_acc_next   = size_acc;
    remaining_next  = remaining;
    digit_seen_next = digit_seen;
    emitted_next    = emitted;
    size_line_done  = 1'b0;
    case (phase)
      PH_SIZE: begin
        if (is_hex) begin
          if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_next = PH_ERROR;
          end else begin
            size_acc_next   = {size_acc[SIZE_BITS-5:0], hex_val};
            digit_seen_next = 1'b1;
          end
        end else if (in_byte == CH_SEMI) begin
          phase_next = PH_EXT;
        end else if (in_byte == CH_CR) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (in_byte == CH_LF) size_line_done = 1'b1;
        else phase_next = PH_ERROR;
      end
      PH_EXT: begin
        if (in_byte == CH_CR) phase_next = PH_EXT_CR;
      end
      PH_EXT_CR: begin
        if (in_byte == CH_LF) size_line_done = 1'b1;
        else if (in_byte != CH_CR) phase_next = PH_EXT;
      end
      PH_DATA: begin
        if (emitted != {LENGTH_BITS{1'b1}}) emitted_next = emitted + 1'b1;
        remaining_next = remaining - 1'b1;
        if (remaining == SIZE_BITS'(1)) phase_next = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (in_byte == CH_CR) phase_next = PH_DATA_LF;
        else phase_next = PH_ERROR;
      end
      PH_DATA_LF: begin
        if (in_byte == CH_LF) begin
          size_acc_next   = '0;
          digit_seen_next = 1'b0;
          phase_next      = PH_SIZE;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    // end of a size line: error, final chunk, or data
    if (size_line_done) begin
      if (!digit_seen) begin
        phase_next = PH_ERROR;
      end else if (size_acc == '0) begin
        phase_next = PH_DONE;
      end else begin
        remaining_next = size_acc;
        phase_next     = PH_DATA;
      end
    end
  end

  // result for this beat
  always_comb begin
    res.data_valid     = (phase == PH_DATA);
    res.data_byte      = (phase == PH_DATA) ? in_byte : 8'd0;
    res.decoded_length = emitted_next;
    if (phase_next == PH_DONE) res.status = STATUS_DONE;
    else if (phase_next == PH_ERROR || last_byte) res.status = STATUS_ERROR;
    else res.status = STATUS_BUSY;
  end

  // state update; a last beat starts a fresh body
  always_ff @(posedge clk) begin
    if (rst || (en && last_byte)) begin
      phase      <= PH_SIZE;
      size_acc   <= '0;
      remaining  <= '0;
      digit_seen <= 1'b0;
      emitted    <= '0;
    end else if (en) begin
      phase      <= phase_next;
      size_acc   <= size_acc_next;
      remaining  <= remaining_next;
      digit_seen <= digit_seen_next;
      emitted    <= emitted_next;
    end
  end

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
// Chunked transfer decoder. Takes one body byte per beat on rx and returns
// exactly one result beat on tx for each, carrying the payload byte (with
// data_valid set when the byte is chunk data), a status (busy, done, error)
// and the count of payload bytes emitted so far in the body. Sustained rate
// is one beat per cycle while tx is ready; a byte passes the input register,
// the single per-byte framing step and then the result register. A byte
// marked last ends the body and the following byte starts a new one.
module chunked_transfer_decoder import ctd_pkg::*; (
  input logic       clk,
  input logic       rst,
  ctd_in_if.sink    rx,
  ctd_out_if.source tx
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        out_valid;
  ctd_result_t out_res;
  ctd_result_t step_res;
  logic        advance;
  logic        step_en;

  assign advance  = !out_valid || tx.ready;
  assign step_en  = s1_valid && advance;
  assign rx.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.in_byte;
      s1_last <= rx.last_byte;
    end
  end

  ctd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (step_en),
    .in_byte   (s1_byte),
    .last_byte (s1_last),
    .res       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= step_res;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.data_byte      = out_res.data_byte;
  assign tx.data_valid     = out_res.data_valid;
  assign tx.status         = out_res.status;
  assign tx.decoded_length = out_res.decoded_length;

endmodule

// ===== rtl/ctd_checker.sv =====
`include "chunked_transfer_decoder_assert.svh"

module ctd_checker import ctd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   tx_valid,
  input logic                   tx_ready,
  input logic [7:0]             data_byte,
  input logic                   data_valid,
  input logic [1:0]             status,
  input logic [LENGTH_BITS-1:0] decoded_length
);

  // no result beat right after reset
  `CTD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !tx_valid)

  // a stalled result beat holds
  `CTD_ASSERT(a_stall_hold, clk, rst, tx_valid && !tx_ready |=> tx_valid && $stable(data_byte) && $stable(data_valid) && $stable(status) && $stable(decoded_length))

  // non-payload beats carry a zero byte
  `CTD_ASSERT(a_idle_byte, clk, rst, tx_valid && !data_valid |-> data_byte == 8'd0)

  // a payload beat has been counted
  `CTD_ASSERT(a_count_payload, clk, rst, tx_valid && data_valid |-> decoded_length != '0)

  // status never takes the unused code
  `CTD_ASSERT(a_status_code, clk, rst, tx_valid |-> status == STATUS_BUSY || status == STATUS_DONE || status == STATUS_ERROR)

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
  .clk            (clk),
  .rst            (rst),
  .tx_valid       (tx.valid),
  .tx_ready       (tx.ready),
  .data_byte      (tx.data_byte),
  .data_valid     (tx.data_valid),
  .status         (tx.status),
  .decoded_length (tx.decoded_length)
);
